// ===== src/pccb_pkg.sv =====
`timescale 1ns / 1ps

package pccb_pkg;

    // Default depth of the residual store
    localparam int MAX_CONSTRAINTS_DEF = 1024;

    // Field widths
    localparam int DATA_W     = 32;
    localparam int INDEX_W    = 10;
    localparam int EPS_W      = 16;
    localparam int IDX_EXT_W  = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Divider geometry: |r| * 2^16 over |coef|, quotient kept to 33 bits
    localparam int DIVIDEND_W = 48;
    localparam int QUOT_W     = 33;
    localparam int DIV_STEPS  = 33;
    localparam int DIV_CNT_W  = 6;

    // Operation codes
    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_UPDATE    = 2'd1;
    localparam logic [1:0] OP_INTERSECT = 2'd2;

    // Register indexes
    localparam logic REG_EPS = 1'b0;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam logic signed [DATA_W-1:0] FULL_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] FULL_POS = 32'sh7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WRITE,
        ST_READ,
        ST_MUL,
        ST_SUB,
        ST_DSTART,
        ST_DWAIT,
        ST_FOLD,
        ST_EMIT
    } pccb_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DATA_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/pccb_cfg.sv =====
`timescale 1ns / 1ps

module pccb_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pccb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pccb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pccb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [pccb_pkg::EPS_W-1:0]       eps
);
    import pccb_pkg::*;

    logic [EPS_W-1:0] eps_reg;
    logic             reg_idx;
    logic             wr_hit;

    // Decode the word index from the byte address
    assign reg_idx = paddr[CFG_ADDR_W-1];
    assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_EPS);

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (wr_hit)
        begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    // Return the addressed register on reads
    always_comb
    begin
        case (reg_idx)
            REG_EPS: prdata = {{(APB_DATA_W-EPS_W){1'b0}}, eps_reg};
            default: prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign eps    = eps_reg;

endmodule

// ===== src/pccb_div.sv =====
`timescale 1ns / 1ps

module pccb_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pccb_pkg::div_req_t  req,
    output pccb_pkg::div_rsp_t  rsp
);
    import pccb_pkg::*;

    localparam int HI_W = DIVIDEND_W - QUOT_W;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [QUOT_W-1:0]    dq_reg;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      hi_ext;
    logic                 fits;

    // Form the trial remainder for one restoring step
    assign trial  = {rem_reg, dq_reg[QUOT_W-1]};
    assign fits   = trial >= {1'b0, req.divisor};
    assign hi_ext = {{(DATA_W+1-HI_W){1'b0}}, req.dividend[DIVIDEND_W-1:QUOT_W]};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift one quotient bit in per cycle; flag quotients of 2^33 and up at start
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= hi_ext[DATA_W-1:0];
            ovf_reg <= hi_ext >= {1'b0, req.divisor};
            dq_reg  <= req.dividend[QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DATA_W'(trial - {1'b0, req.divisor});
            end
            else
            begin
                rem_reg <= trial[DATA_W-1:0];
            end
            dq_reg <= {dq_reg[QUOT_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.ovf      = ovf_reg;
    assign rsp.quotient = dq_reg;

endmodule

// ===== src/polytope_coordinate_chord_bounds_top.sv =====
// Coordinate chord bounds: keeps a store of Q16.16 constraint residuals and
// folds residual/coefficient quotients into a running lower and upper step
// bound, emitting both on the intersect word marked last. Words are taken one
// at a time and in_ready is low while one is in work: a write passes through
// dispatch and write, a residual update through dispatch, store read, one 32x32
// multiply, saturating subtract and write back, an orthogonal intersect row
// ends at dispatch, and a regular intersect row waits on the radix-2 divider
// that retires one of 33 quotient bits per cycle. A last row then passes
// through emit, which waits until the previous result word is taken. The
// store needs no clearing pass after reset; rows must be written before they
// are read. eps is written over the APB port at byte address 0.
`timescale 1ns / 1ps

module polytope_coordinate_chord_bounds_top #(
    parameter int MAX_CONSTRAINTS = pccb_pkg::MAX_CONSTRAINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pccb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pccb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pccb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       op,
    input  logic [pccb_pkg::INDEX_W-1:0]     index,
    input  logic signed [pccb_pkg::DATA_W-1:0] coef,
    input  logic signed [pccb_pkg::DATA_W-1:0] value,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [pccb_pkg::DATA_W-1:0] lower_bound,
    output logic signed [pccb_pkg::DATA_W-1:0] upper_bound
);
    import pccb_pkg::*;

    localparam int ADDR_W = (MAX_CONSTRAINTS <= 2) ? 1 : $clog2(MAX_CONSTRAINTS);

    pccb_state_t state_reg, state_next;

    logic [1:0]                op_reg;
    logic [INDEX_W-1:0]        index_reg;
    logic signed [DATA_W-1:0]  coef_reg;
    logic signed [DATA_W-1:0]  value_reg;
    logic                      last_reg;
    logic signed [63:0]        prod_reg;
    logic signed [DATA_W-1:0]  rd_data_reg;
    logic                      neg_reg;
    logic signed [DATA_W-1:0]  lower_reg;
    logic signed [DATA_W-1:0]  upper_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_lower_reg;
    logic signed [DATA_W-1:0]  out_upper_reg;

    logic [EPS_W-1:0]          eps;
    logic [IDX_EXT_W-1:0]      idx_ext;
    logic                      row_ok;
    logic [ADDR_W-1:0]         addr;
    logic [DATA_W-1:0]         coef_mag;
    logic                      skew;
    logic                      rd_en;
    logic                      wr_en;
    logic signed [DATA_W-1:0]  wr_data;
    logic signed [DATA_W-1:0]  resid;
    logic [DATA_W-1:0]         resid_mag;
    logic signed [47:0]        scaled;
    logic signed [DATA_W-1:0]  prod_sat;
    logic signed [DATA_W:0]    diff;
    logic signed [DATA_W-1:0]  t_val;
    logic                      emit_go;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic [DATA_W-1:0] mem [MAX_CONSTRAINTS];

    pccb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eps     (eps)
    );

    pccb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Decode the row address and range check
    assign idx_ext = {{(IDX_EXT_W-INDEX_W){1'b0}}, index_reg};
    assign row_ok  = idx_ext < IDX_EXT_W'(MAX_CONSTRAINTS);
    assign addr    = idx_ext[ADDR_W-1:0];

    // Test coefficient magnitude against the threshold
    assign coef_mag = coef_reg[DATA_W-1] ? DATA_W'(-coef_reg) : coef_reg;
    assign skew     = coef_mag > {{(DATA_W-EPS_W){1'b0}}, eps};

    // Scale the product toward minus infinity, saturate, subtract and saturate
    assign scaled = prod_reg[63:16];
    always_comb
    begin
        if ((&scaled[47:31]) || !(|scaled[47:31]))
        begin
            prod_sat = scaled[DATA_W-1:0];
        end
        else if (scaled[47])
        begin
            prod_sat = FULL_NEG;
        end
        else
        begin
            prod_sat = FULL_POS;
        end
        diff = {rd_data_reg[DATA_W-1], rd_data_reg} - {prod_sat[DATA_W-1], prod_sat};
    end

    // Residual seen by an intersect row; out-of-range rows read as zero
    assign resid     = row_ok ? rd_data_reg : '0;
    assign resid_mag = resid[DATA_W-1] ? DATA_W'(-resid) : resid;

    // Sign and saturate the quotient
    always_comb
    begin
        if (div_rsp.ovf)
        begin
            t_val = neg_reg ? FULL_NEG : FULL_POS;
        end
        else if (!neg_reg)
        begin
            t_val = (div_rsp.quotient > QUOT_W'(FULL_POS)) ? FULL_POS
                                                           : div_rsp.quotient[DATA_W-1:0];
        end
        else if (div_rsp.quotient > {1'b0, FULL_NEG})
        begin
            t_val = FULL_NEG;
        end
        else
        begin
            t_val = DATA_W'(-div_rsp.quotient);
        end
    end

    assign emit_go = !out_valid_reg || out_ready;

    // Next state and datapath controls
    always_comb
    begin
        state_next       = state_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_data          = value_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {resid_mag, 16'd0};
        div_req.divisor  = coef_mag;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (op_reg)
                    OP_WRITE:     state_next = ST_WRITE;
                    OP_UPDATE:    state_next = row_ok ? ST_READ : ST_IDLE;
                    OP_INTERSECT:
                    begin
                        if (skew)
                        begin
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = last_reg ? ST_EMIT : ST_IDLE;
                        end
                    end
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_WRITE:
            begin
                wr_en      = row_ok;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                rd_en      = row_ok;
                state_next = (op_reg == OP_UPDATE) ? ST_MUL : ST_DSTART;
            end
            ST_MUL:
            begin
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                wr_en = 1'b1;
                if (diff[DATA_W] != diff[DATA_W-1])
                begin
                    wr_data = diff[DATA_W] ? FULL_NEG : FULL_POS;
                end
                else
                begin
                    wr_data = diff[DATA_W-1:0];
                end
                state_next = ST_IDLE;
            end
            ST_DSTART:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= op;
            index_reg <= index;
            coef_reg  <= coef;
            value_reg <= value;
            last_reg  <= last;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= value_reg * coef_reg;
        end
        if (state_reg == ST_DSTART)
        begin
            neg_reg <= resid[DATA_W-1] ^ coef_reg[DATA_W-1];
        end
    end

    // Residual store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // Fold quotients into the running bounds and restart them on emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= FULL_NEG;
            upper_reg <= FULL_POS;
        end
        else if (state_reg == ST_FOLD)
        begin
            if (coef_reg[DATA_W-1])
            begin
                if (t_val > lower_reg)
                begin
                    lower_reg <= t_val;
                end
            end
            else if (t_val < upper_reg)
            begin
                upper_reg <= t_val;
            end
        end
        else if (state_reg == ST_EMIT && emit_go)
        begin
            lower_reg <= FULL_NEG;
            upper_reg <= FULL_POS;
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_EMIT && emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && emit_go)
        begin
            out_lower_reg <= lower_reg;
            out_upper_reg <= upper_reg;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign lower_bound = out_lower_reg;
    assign upper_bound = out_upper_reg;

endmodule

// ===== sim/tb_polytope_coordinate_chord_bounds_top.sv =====
`timescale 1ns / 1ps

module tb_polytope_coordinate_chord_bounds_top;

    import pccb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sh0001_0000;
    localparam int ROWS = MAX_CONSTRAINTS_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]               op;
        logic [INDEX_W-1:0]       row;
        logic signed [DATA_W-1:0] coef;
        logic signed [DATA_W-1:0] val;
        logic                     last;
        bit                       drain;
    } chord_word_t;

    typedef struct {
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] upper;
    } chord_bounds_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0]     pwdata = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                op = OP_WRITE;
    logic [INDEX_W-1:0]        index = '0;
    logic signed [DATA_W-1:0]  coef = '0;
    logic signed [DATA_W-1:0]  value = '0;
    logic                      last = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [DATA_W-1:0]  lower_bound;
    logic signed [DATA_W-1:0]  upper_bound;

    // Predictor state
    logic signed [DATA_W-1:0]  residual [0:ROWS-1];
    logic signed [DATA_W-1:0]  run_lower = FULL_NEG;
    logic signed [DATA_W-1:0]  run_upper = FULL_POS;
    logic [EPS_W-1:0]          cfg_eps = EPS_RESET;

    // Stimulus bookkeeping
    chord_word_t               words_pending [$];
    chord_bounds_t             bounds_due [$];
    chord_word_t               offered;
    bit                        row_live [0:ROWS-1];
    int unsigned               live_rows [$];
    int                        words_made = 0;
    int                        send_idle_pct = 0;
    int                        recv_stall_pct = 0;
    int                        results_owed = 0;
    int                        results_taken = 0;
    int                        bound_errors = 0;
    int                        stall_left = 0;
    bit                        hold_req = 1'b0;

    polytope_coordinate_chord_bounds_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .index       (index),
        .coef        (coef),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_word(input longint v);
        if (v > longint'(FULL_POS))
            return FULL_POS;
        if (v < longint'(FULL_NEG))
            return FULL_NEG;
        return v[DATA_W-1:0];
    endfunction

    // Apply one accepted word to the residual store and the running bounds;
    // return 1 when the word closes an intersect pass
    function automatic bit fold_word(input chord_word_t w);
        longint        prod;
        longint        mag;
        logic signed [DATA_W-1:0] quot;
        chord_bounds_t b;
        case (w.op)
            OP_WRITE:
                residual[w.row] = w.val;
            OP_UPDATE:
            begin
                // floor-scaled product, then saturating subtract
                prod = sat_word((longint'(w.val) * longint'(w.coef)) >>> 16);
                residual[w.row] = sat_word(longint'(residual[w.row]) - prod);
            end
            OP_INTERSECT:
            begin
                mag = (w.coef < 0) ? -longint'(w.coef) : longint'(w.coef);
                // skip rows orthogonal to the chosen coordinate
                if (mag > longint'(cfg_eps))
                begin
                    quot = sat_word((longint'(residual[w.row]) * 65536) / longint'(w.coef));
                    if (w.coef < 0)
                    begin
                        if (quot > run_lower)
                            run_lower = quot;
                    end
                    else if (quot < run_upper)
                        run_upper = quot;
                end
                if (w.last)
                begin
                    b.lower = run_lower;
                    b.upper = run_upper;
                    bounds_due.push_back(b);
                    run_lower = FULL_NEG;
                    run_upper = FULL_POS;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Driver: present the next pending word, hold it until taken
    always @(posedge clk)
    begin : drive_words
        bit fire;
        bit gap;
        if (rst_n)
        begin
            fire = in_valid && in_ready;
            if (fire)
            begin
                if (fold_word(offered))
                    results_owed <= results_owed + 1;
            end
            if (!in_valid || fire)
            begin
                gap = (send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct);
                if (words_pending.size() != 0 && !gap &&
                    !(words_pending[0].drain && (in_valid || results_owed != results_taken)))
                begin
                    offered = words_pending.pop_front();
                    in_valid <= 1'b1;
                    op       <= offered.op;
                    index    <= offered.row;
                    coef     <= offered.coef;
                    value    <= offered.val;
                    last     <= offered.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down on its own
    always @(posedge clk)
    begin
        if (hold_req)
            stall_left <= HOLD_CYCLES;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // Monitor: check each bounds word against the oldest prediction
    always @(posedge clk)
    begin : watch_bounds
        chord_bounds_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_taken <= results_taken + 1;
                if (bounds_due.size() == 0)
                begin
                    if (bound_errors < 10)
                        $display("unexpected bounds word: lower %0d upper %0d",
                                 lower_bound, upper_bound);
                    bound_errors++;
                end
                else
                begin
                    want = bounds_due.pop_front();
                    if (lower_bound !== want.lower)
                    begin
                        if (bound_errors < 10)
                            $display("lower_bound mismatch: expected %0d, got %0d",
                                     want.lower, lower_bound);
                        bound_errors++;
                    end
                    if (upper_bound !== want.upper)
                    begin
                        if (bound_errors < 10)
                            $display("upper_bound mismatch: expected %0d, got %0d",
                                     want.upper, upper_bound);
                        bound_errors++;
                    end
                end
            end
            out_ready <= (stall_left == 0) &&
                         !((recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct));
        end
    end

    // Queue one word and track which rows hold a residual
    task automatic push_word(input logic [1:0] o, input int unsigned r,
                             input logic signed [DATA_W-1:0] c,
                             input logic signed [DATA_W-1:0] v,
                             input bit l, input bit d);
        chord_word_t w;
        w.op    = o;
        w.row   = INDEX_W'(r);
        w.coef  = c;
        w.val   = v;
        w.last  = l;
        w.drain = d;
        words_pending.push_back(w);
        if (o != OP_UNUSED)
            words_made++;
        if (o == OP_WRITE && !row_live[w.row])
        begin
            row_live[w.row] = 1'b1;
            live_rows.push_back(r);
        end
    endtask

    function automatic int unsigned pick_row();
        return live_rows[$urandom_range(live_rows.size() - 1)];
    endfunction

    // Residual or step value: extremes, zero, full range, or a few units
    function automatic logic signed [DATA_W-1:0] rand_q();
        case ($urandom_range(7))
            0: return FULL_POS;
            1: return FULL_NEG;
            2: return '0;
            3: return $urandom;
            default: return int'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    // Coefficient: orthogonal, at the threshold edge, extremes, or moderate
    function automatic logic signed [DATA_W-1:0] pick_coef();
        logic signed [DATA_W-1:0] c;
        case ($urandom_range(9))
            0: c = '0;
            1: c = $urandom_range(cfg_eps);
            2: c = cfg_eps + 1;
            3: c = FULL_NEG;
            4: c = FULL_POS;
            5: c = $urandom;
            default: c = $urandom_range(32'h0004_0000, 32'h0000_1000);
        endcase
        if ($urandom_range(1))
            c = -c;
        return c;
    endfunction

    // One short sequence: an intersect pass, updates, writes, or noise
    task automatic make_pass(input bit drain_first);
        int kind;
        int n;
        kind = $urandom_range(99);
        if (live_rows.size() < 4)
            kind = 70;
        if (kind < 45)
        begin
            n = $urandom_range(6, 1);
            for (int k = 0; k < n; k++)
                push_word(OP_INTERSECT, pick_row(), pick_coef(), $urandom,
                          k == n - 1, drain_first && k == 0);
        end
        else if (kind < 60)
        begin
            n = $urandom_range(3, 1);
            for (int k = 0; k < n; k++)
                push_word(OP_UPDATE, pick_row(), pick_coef(), rand_q(),
                          $urandom_range(7) == 0, drain_first && k == 0);
        end
        else if (kind < 80)
        begin
            n = $urandom_range(4, 1);
            for (int k = 0; k < n; k++)
                push_word(OP_WRITE, $urandom_range(ROWS - 1), $urandom, rand_q(),
                          $urandom_range(7) == 0, drain_first && k == 0);
        end
        else if (kind < 90)
            push_word(OP_UNUSED, $urandom_range(ROWS - 1), $urandom, $urandom,
                      1'($urandom_range(1)), drain_first);
        else
        begin
            // broken pass: rows without a closing last
            n = $urandom_range(3, 1);
            for (int k = 0; k < n; k++)
                push_word(OP_INTERSECT, pick_row(), pick_coef(), $urandom,
                          1'b0, drain_first && k == 0);
        end
    endtask

    // Wait for the block to drain, then let any in-flight row finish
    task automatic wait_quiet();
        while (words_pending.size() != 0 || in_valid || bounds_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write of the threshold register: setup cycle, then access cycle
    task automatic write_eps(input logic [EPS_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(REG_EPS) << 2;
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_eps = v;
    endtask

    initial
    begin
        logic [EPS_W-1:0] eps_plan [6];
        int phase_target;
        int pass_count;
        eps_plan = '{16'd0, 16'hFFFF, 16'd300, 16'd0, 16'd1, 16'd0};
        eps_plan[3] = EPS_W'($urandom_range(16'hFFFF));
        pass_count = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words under the reset threshold
        push_word(OP_WRITE, 0, '0, FULL_POS, 1'b0, 1'b0);
        push_word(OP_WRITE, ROWS - 1, '0, FULL_NEG, 1'b0, 1'b0);
        // last on a write is ignored
        push_word(OP_WRITE, 5, '0, '0, 1'b1, 1'b0);
        push_word(OP_WRITE, 7, '0, 32'sh0003_8000, 1'b0, 1'b0);
        // pass of one skipped row emits the untouched bounds
        push_word(OP_INTERSECT, 5, '0, '0, 1'b1, 1'b0);
        // coefficient magnitude equal to the threshold is skipped
        push_word(OP_INTERSECT, 0, 32'sd1, '0, 1'b0, 1'b0);
        push_word(OP_INTERSECT, 0, -32'sd1, '0, 1'b0, 1'b0);
        // quotients that saturate either way
        push_word(OP_INTERSECT, 0, 32'sd2, '0, 1'b0, 1'b0);
        push_word(OP_INTERSECT, ROWS - 1, 32'sd2, '0, 1'b0, 1'b0);
        push_word(OP_INTERSECT, 7, FULL_NEG, '0, 1'b0, 1'b0);
        push_word(OP_INTERSECT, ROWS - 1, -32'sd2, '0, 1'b1, 1'b0);
        // products at full scale, floor rounding, saturating subtract
        push_word(OP_UPDATE, 0, FULL_NEG, FULL_NEG, 1'b0, 1'b0);
        push_word(OP_UPDATE, ROWS - 1, FULL_NEG, FULL_POS, 1'b0, 1'b0);
        push_word(OP_UPDATE, 7, 32'sd1, -32'sd1, 1'b0, 1'b0);
        push_word(OP_UPDATE, 5, FULL_POS, FULL_POS, 1'b1, 1'b0);
        push_word(OP_UPDATE, 5, ONE_Q, ONE_Q, 1'b0, 1'b0);
        push_word(OP_UPDATE, 5, ONE_Q, ONE_Q, 1'b0, 1'b0);
        // unused op does nothing, even with last
        push_word(OP_UNUSED, 3, FULL_NEG, FULL_POS, 1'b1, 1'b0);
        push_word(OP_INTERSECT, 7, ONE_Q, '0, 1'b0, 1'b0);
        push_word(OP_INTERSECT, 5, -ONE_Q, '0, 1'b0, 1'b0);
        push_word(OP_INTERSECT, 0, FULL_POS, '0, 1'b0, 1'b0);
        push_word(OP_INTERSECT, 5, FULL_NEG, '0, 1'b1, 1'b0);

        // Random phases, each setting its threshold and idling mix
        for (int p = 0; p < 6; p++)
        begin
            wait_quiet();
            write_eps(eps_plan[p]);
            @(negedge clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (p == 0)
            begin
                // hold off the receiver while short passes pile up
                hold_req = 1'b1;
                @(negedge clk);
                hold_req = 1'b0;
                for (int k = 0; k < 8; k++)
                    push_word(OP_INTERSECT, pick_row(), '0, $urandom, 1'b1, 1'b0);
            end
            phase_target = words_made + 330;
            while (words_made < phase_target)
            begin
                make_pass(pass_count % 40 == 39);
                pass_count++;
            end
        end

        wait_quiet();
        if (bound_errors == 0)
            $display("polytope_coordinate_chord_bounds_top regression: pass");
        else
            $display("polytope_coordinate_chord_bounds_top regression: fail");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #4_000_000;
        $display("polytope_coordinate_chord_bounds_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/pccb_pkg.sv
src/pccb_cfg.sv
src/pccb_div.sv
src/polytope_coordinate_chord_bounds_top.sv
sim/tb_polytope_coordinate_chord_bounds_top.sv
